/* rtl/bspt_pkg.sv */
// ----------------------------------------------------------------------------
// BSP tree traversal package
// Shared constants, codes, types and helpers for the depth-order traversal.
// ----------------------------------------------------------------------------
`default_nettype none

package bspt_pkg;

  // Sizes of the tree, the result stream and the coordinate compare.
  localparam int MAX_LEAVES  = 64;
  localparam int NODE_SLOTS  = 128;
  localparam int COORD_BITS  = 32;
  localparam int STACK_DEPTH = 7;

  localparam int ADDR_W = $clog2(NODE_SLOTS);
  localparam int CHILD_W = ADDR_W + 1;
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(MAX_LEAVES + 1);

  // Action codes of an input item.
  localparam logic [1:0] ACT_CLEAR     = 2'd0;
  localparam logic [1:0] ACT_WRITE     = 2'd1;
  localparam logic [1:0] ACT_POINT     = 2'd2;
  localparam logic [1:0] ACT_DIRECTION = 2'd3;

  // Node kind codes.
  localparam logic [1:0] KIND_X    = 2'd0;
  localparam logic [1:0] KIND_Y    = 2'd1;
  localparam logic [1:0] KIND_LEAF = 2'd3;

  localparam logic [ADDR_W-1:0] ROOT_SLOT = ADDR_W'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One node memory entry.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
  } node_t;

  // Access to the node memory.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    node_t             wr_node;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  // Events from the walker to the result buffer.
  typedef struct packed {
    logic        leaf;
    logic        done;
    logic [31:0] index;
  } evt_t;

  // Low COORD_BITS bits of a field, taken as a signed number.
  function automatic coord_t coord_of(input logic [31:0] raw);
    coord_of = coord_t'(raw[COORD_BITS-1:0]);
  endfunction

endpackage

`default_nettype wire

/* rtl/bspt_if.sv */
// ----------------------------------------------------------------------------
// BSP tree traversal channels
// Valid/ready channel interfaces for query items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface bspt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [6:0]         node_slot;
  logic [1:0]         node_kind;
  logic signed [31:0] node_word;
  logic signed [31:0] ref_x;
  logic signed [31:0] ref_y;
  logic signed [31:0] ref_z;

  modport source (
    output valid, action, node_slot, node_kind, node_word, ref_x, ref_y, ref_z,
    input  ready
  );
  modport sink (
    input  valid, action, node_slot, node_kind, node_word, ref_x, ref_y, ref_z,
    output ready
  );
endinterface

interface bspt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] particle_index;
  logic               last;
  logic               empty_res;

  modport source (
    output valid, particle_index, last, empty_res,
    input  ready
  );
  modport sink (
    input  valid, particle_index, last, empty_res,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/bspt_node_ram.sv */
// ----------------------------------------------------------------------------
// BSP tree node memory
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bspt_node_ram (
  input  wire logic              clk,
  input  wire bspt_pkg::ram_req_t req,
  output bspt_pkg::node_t         rd_node
);
  import bspt_pkg::*;

  node_t mem [NODE_SLOTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_node;
    end
  end

  // Read port; the data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_node <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/bspt_walker.sv */
// ----------------------------------------------------------------------------
// BSP tree walker
// Takes input items, loads nodes, and walks the tree one node per cycle while the result buffer is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bspt_walker (
  input  wire logic              clk,
  input  wire logic              rst,
  bspt_in_if.sink                req,
  input  wire bspt_pkg::node_t   rd_node,
  input  wire logic              buf_free,
  output bspt_pkg::ram_req_t     ram_req,
  output bspt_pkg::evt_t         evt
);
  import bspt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]        state, state_next;
  logic [ADDR_W-1:0] cur, cur_next;
  logic [LVL_W-1:0]  level, level_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              present, present_next;
  logic              dir;
  coord_t            ref_c [3];
  logic [ADDR_W-1:0] stack [STACK_DEPTH];

  logic              push_en;
  logic [ADDR_W-1:0] push_slot;

  // Split decision and child slots of the node on the read port.
  coord_t            sel_ref;
  coord_t            thr;
  logic              go_lo;
  logic [CHILD_W-1:0] lo_child, hi_child, first, second;
  logic              first_ok, second_ok;

  always_comb begin
    case (rd_node.kind)
      KIND_X:  sel_ref = ref_c[0];
      KIND_Y:  sel_ref = ref_c[1];
      default: sel_ref = ref_c[2];
    endcase
    thr       = dir ? '0 : coord_of(rd_node.word);
    go_lo     = sel_ref > thr;
    lo_child  = {cur, 1'b0};
    hi_child  = lo_child + CHILD_W'(1);
    first     = go_lo ? lo_child : hi_child;
    second    = go_lo ? hi_child : lo_child;
    first_ok  = first < CHILD_W'(NODE_SLOTS);
    second_ok = second < CHILD_W'(NODE_SLOTS);
  end

  assign req.ready = (state == S_IDLE);

  // Sequencer: one node evaluated and the next one read in each cycle while the result buffer is free.
  always_comb begin
    logic              have_next;
    logic [ADDR_W-1:0] next_slot;

    have_next    = 1'b0;
    next_slot    = cur;
    state_next   = state;
    cur_next     = cur;
    level_next   = level;
    count_next   = count;
    present_next = present;
    push_en      = 1'b0;
    push_slot    = second[ADDR_W-1:0];

    ram_req.wr_en        = 1'b0;
    ram_req.wr_addr      = req.node_slot[ADDR_W-1:0];
    ram_req.wr_node.kind = req.node_kind;
    ram_req.wr_node.word = req.node_word;
    ram_req.rd_en        = 1'b0;
    ram_req.rd_addr      = cur;

    evt.leaf  = 1'b0;
    evt.done  = 1'b0;
    evt.index = rd_node.word;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.action)
            ACT_CLEAR: begin
              present_next = 1'b0;
            end
            ACT_WRITE: begin
              if (req.node_slot != 7'd0 &&
                  {1'b0, req.node_slot} < 8'(NODE_SLOTS)) begin
                ram_req.wr_en = 1'b1;
                present_next  = 1'b1;
              end
            end
            default: begin
              if (present) begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = ROOT_SLOT;
                cur_next        = ROOT_SLOT;
                level_next      = '0;
                count_next      = '0;
                state_next      = S_WALK;
              end else begin
                state_next = S_FINISH;
              end
            end
          endcase
        end
      end

      S_WALK: begin
        if (buf_free) begin
          if (rd_node.kind == KIND_LEAF) begin
            evt.leaf   = 1'b1;
            count_next = count + CNT_W'(1);
          end else if (first_ok) begin
            have_next = 1'b1;
            next_slot = first[ADDR_W-1:0];
            if (second_ok && level < LVL_W'(STACK_DEPTH)) begin
              push_en    = 1'b1;
              level_next = level + LVL_W'(1);
            end
          end else if (second_ok && level < LVL_W'(STACK_DEPTH)) begin
            // Pushing the second child and popping it at once.
            have_next = 1'b1;
            next_slot = second[ADDR_W-1:0];
          end

          if (rd_node.kind == KIND_LEAF && count == CNT_W'(MAX_LEAVES - 1)) begin
            state_next = S_FINISH;
          end else if (!have_next && level == '0) begin
            state_next = S_FINISH;
          end else begin
            if (!have_next) begin
              level_next = level - LVL_W'(1);
              next_slot  = stack[SP_W'(level - LVL_W'(1))];
            end
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = next_slot;
            cur_next        = next_slot;
          end
        end
      end

      S_FINISH: begin
        if (buf_free) begin
          evt.done   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      level   <= '0;
      count   <= '0;
      present <= 1'b0;
    end else begin
      state   <= state_next;
      level   <= level_next;
      count   <= count_next;
      present <= present_next;
    end
  end

  // Current slot, stack of deferred children and the query captured at accept.
  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (push_en) begin
      stack[SP_W'(level)] <= push_slot;
    end
    if (state == S_IDLE && req.valid) begin
      dir      <= (req.action == ACT_DIRECTION);
      ref_c[0] <= coord_of(req.ref_x);
      ref_c[1] <= coord_of(req.ref_y);
      ref_c[2] <= coord_of(req.ref_z);
    end
  end

endmodule

`default_nettype wire

/* rtl/bspt_res_buf.sv */
// ----------------------------------------------------------------------------
// BSP tree result buffer
// Holds one leaf until the next one or the end shows whether it is the last.
// ----------------------------------------------------------------------------
`default_nettype none

module bspt_res_buf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bspt_pkg::evt_t  evt,
  output logic                 buf_free,
  bspt_out_if.source           res
);
  import bspt_pkg::*;

  logic        hold_valid;
  logic [31:0] hold_index;
  logic        out_valid;
  logic [31:0] out_index;
  logic        out_last;
  logic        out_empty;

  // The output register can take a new result now or after this transfer.
  assign buf_free = !out_valid || res.ready;

  assign res.valid          = out_valid;
  assign res.particle_index = out_index;
  assign res.last           = out_last;
  assign res.empty_res      = out_empty;

  // Valid flags. Events only come while the output register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (evt.done) begin
        hold_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else if (evt.leaf) begin
        hold_valid <= 1'b1;
        out_valid  <= hold_valid || (out_valid && !res.ready);
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: a held leaf moves out when a newer one arrives or at the end.
  always_ff @(posedge clk) begin
    if (evt.done) begin
      out_index <= hold_valid ? hold_index : 32'd0;
      out_last  <= 1'b1;
      out_empty <= !hold_valid;
    end else if (evt.leaf) begin
      hold_index <= evt.index;
      if (hold_valid) begin
        out_index <= hold_index;
        out_last  <= 1'b0;
        out_empty <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/bsp_tree_depth_order_traversal_core.sv */
// ----------------------------------------------------------------------------
// BSP tree depth-order traversal core
// Loads a heap-layout split tree and streams leaf indices in depth order.
// ----------------------------------------------------------------------------
//   channel | dir | payload                                        | transfer
//   req     | in  | action, node_slot, node_kind, node_word, ref_* | valid & ready
//   res     | out | particle_index, last, empty_res                | valid & ready
//
// A clear or node write is accepted directly while idle. A query starts, then
// visits one node per cycle while results can move (up to 2*MAX_LEAVES-1 nodes)
// and closes; the node rate is set by the single read port of the node memory.
// Reset clears the walker state, the tree-present flag and the result flags.
// A stalled result register holds the walk in place; req.ready is high only
// while no query is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_tree_depth_order_traversal_core (
  input  wire logic clk,
  input  wire logic rst,
  bspt_in_if.sink   req,
  bspt_out_if.source res
);
  import bspt_pkg::*;

  ram_req_t ram_req;
  node_t    rd_node;
  evt_t     evt;
  logic     buf_free;

  bspt_node_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_node (rd_node)
  );

  bspt_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_node  (rd_node),
    .buf_free (buf_free),
    .ram_req  (ram_req),
    .evt      (evt)
  );

  bspt_res_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt),
    .buf_free (buf_free),
    .res      (res)
  );

endmodule

`default_nettype wire

/* rtl/bspt_checker.sv */
// ----------------------------------------------------------------------------
// BSP tree traversal port checker
// Checks the port behavior of the traversal core over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bspt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic [1:0]  req_action,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] res_index,
  input wire logic        res_last,
  input wire logic        res_empty
);

  // A stalled result holds its value.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_index) && $stable(res_last))
    else $error("result changed while stalled");

  // An empty result is the only and final result, with a zero index.
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_empty |-> res_last && res_index == 32'd0)
    else $error("malformed empty result");

  // A query closes the input while its walk runs.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_action[1] |=> !req_ready)
    else $error("input open right after a query");

  // Clears and writes leave the input open.
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !req_action[1] |=> req_ready)
    else $error("input closed after a node load");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind bsp_tree_depth_order_traversal_core bspt_checker u_bspt_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_action (req.action),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_index  (res.particle_index),
  .res_last   (res.last),
  .res_empty  (res.empty_res)
);

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// BSP tree depth-order traversal testbench
// Loads split trees into the core, runs point and direction queries over them
// and checks every leaf index, last flag and empty flag against a walk of a
// node memory kept inside the bench. Both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bspt_pkg::*;

  // The package names no Z axis code.
  localparam logic [1:0] KIND_Z = 2'd2;

  localparam coord_t C_MAX = 32'sh7FFF_FFFF;
  localparam coord_t C_MIN = 32'sh8000_0000;
  localparam coord_t ONE_Q = 32'sh0001_0000;

  localparam int STALL_LIMIT = 4000;
  localparam int MAX_PRINTED = 100;

  // One request item as it goes over the request channel.
  typedef struct packed {
    logic [1:0]         action;
    logic [6:0]         node_slot;
    logic [1:0]         node_kind;
    logic signed [31:0] node_word;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_z;
  } tree_cmd_t;

  // One leaf result as it goes over the result channel.
  typedef struct packed {
    logic signed [31:0] particle_index;
    logic               last;
    logic               empty_res;
  } leaf_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bspt_in_if  req_ch ();
  bspt_out_if res_ch ();

  bsp_tree_depth_order_traversal_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always #1ns clk = ~clk;

  // Commands waiting to be driven and leaf results waiting to arrive.
  tree_cmd_t req_backlog[$];
  leaf_res_t expected_leaves[$];

  // Node memory as the core should hold it, updated on each accepted command.
  logic [1:0]  node_kind_mem[NODE_SLOTS];
  logic [31:0] node_word_mem[NODE_SLOTS];
  bit          tree_loaded;

  // Shadow of the node memory as the generator leaves it, which runs ahead.
  bit          gen_written[NODE_SLOTS];
  logic [1:0]  gen_kind[NODE_SLOTS];
  bit          gen_present;
  coord_t      split_pool[$];
  int          phase_items;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  tree_cmd_t held_cmd;
  leaf_res_t head_leaf;
  int        stall_cycles;
  int        mismatches = 0;
  int        results_checked = 0;
  int        n_writes = 0;
  int        n_clears = 0;
  int        n_point = 0;
  int        n_dir = 0;
  int        n_empty = 0;
  int        n_full_runs = 0;

  // Work out the leaf results that one accepted command causes.
  task automatic walk_tree(input tree_cmd_t cmd);
    coord_t      pt[3];
    coord_t      thr;
    logic [6:0]  pend[STACK_DEPTH];
    leaf_res_t   run_res[MAX_LEAVES];
    int          lvl;
    int          cur;
    int          nxt;
    int          first;
    int          second;
    int          found;
    bit          have_next;
    case (cmd.action)
      ACT_CLEAR: begin
        tree_loaded = 1'b0;
        n_clears++;
      end
      ACT_WRITE: begin
        n_writes++;
        if (cmd.node_slot != 7'd0) begin
          node_kind_mem[cmd.node_slot] = cmd.node_kind;
          node_word_mem[cmd.node_slot] = cmd.node_word;
          tree_loaded = 1'b1;
        end
      end
      default: begin
        if (cmd.action == ACT_POINT) n_point++;
        else n_dir++;
        found = 0;
        if (tree_loaded) begin
          pt[0] = coord_t'(cmd.ref_x);
          pt[1] = coord_t'(cmd.ref_y);
          pt[2] = coord_t'(cmd.ref_z);
          lvl = 0;
          cur = ROOT_SLOT;
          while (1) begin
            have_next = 1'b0;
            nxt = 0;
            if (cur < NODE_SLOTS) begin
              if (node_kind_mem[cur] == KIND_LEAF) begin
                run_res[found] = '{node_word_mem[cur], 1'b0, 1'b0};
                found++;
                if (found >= MAX_LEAVES) break;
              end else begin
                // Direction queries split at zero on every axis.
                thr = (cmd.action == ACT_POINT) ? coord_t'(node_word_mem[cur]) : '0;
                if (pt[node_kind_mem[cur]] > thr) begin
                  first = 2 * cur;
                  second = 2 * cur + 1;
                end else begin
                  first = 2 * cur + 1;
                  second = 2 * cur;
                end
                if (second < NODE_SLOTS && lvl < STACK_DEPTH) begin
                  pend[lvl] = second[6:0];
                  lvl++;
                end
                if (first < NODE_SLOTS) begin
                  nxt = first;
                  have_next = 1'b1;
                end
              end
            end
            if (!have_next) begin
              if (lvl == 0) break;
              lvl--;
              nxt = pend[lvl];
            end
            cur = nxt;
          end
        end
        // An empty tree and a walk that meets no leaf look the same.
        if (found == 0) begin
          expected_leaves.insert(expected_leaves.size(), '{32'sd0, 1'b1, 1'b1});
          n_empty++;
        end else begin
          run_res[found - 1].last = 1'b1;
          for (int i = 0; i < found; i++)
            expected_leaves.insert(expected_leaves.size(), run_res[i]);
          if (found == MAX_LEAVES) n_full_runs++;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] result %0d: %s got %h, expected %h",
               $time, results_checked, what, got, want);
    mismatches++;
  endtask

  // Queue one command and follow its effect on the generator's shadow.
  task automatic push_item(input logic [1:0] action, input int slot,
                           input logic [1:0] kind, input logic [31:0] word,
                           input coord_t x, input coord_t y, input coord_t z);
    tree_cmd_t cmd;
    cmd = '{action, slot[6:0], kind, word, x, y, z};
    req_backlog.insert(req_backlog.size(), cmd);
    phase_items++;
    if (action == ACT_CLEAR) gen_present = 1'b0;
    if (action == ACT_WRITE && slot[6:0] != 7'd0) begin
      gen_written[slot[6:0]] = 1'b1;
      gen_kind[slot[6:0]] = kind;
      gen_present = 1'b1;
      if (kind != KIND_LEAF) begin
        split_pool.insert(split_pool.size(), coord_t'(word));
        if (split_pool.size() > 32) void'(split_pool.pop_front());
      end
    end
  endtask

  task automatic put_write(input int slot, input logic [1:0] kind, input logic [31:0] word);
    push_item(ACT_WRITE, slot, kind, word, $urandom, $urandom, $urandom);
  endtask

  task automatic put_clear();
    push_item(ACT_CLEAR, $urandom_range(127), 2'($urandom_range(3)), $urandom,
              $urandom, $urandom, $urandom);
  endtask

  // Any node the walk can reach and that was never loaded becomes a leaf.
  task automatic patch_holes(input int slot);
    if (slot < NODE_SLOTS) begin
      if (!gen_written[slot]) begin
        put_write(slot, KIND_LEAF, $urandom);
      end else if (gen_kind[slot] != KIND_LEAF) begin
        patch_holes(2 * slot);
        patch_holes(2 * slot + 1);
      end
    end
  endtask

  task automatic put_query(input logic [1:0] action, input coord_t x, input coord_t y,
                           input coord_t z);
    if (gen_present) patch_holes(ROOT_SLOT);
    push_item(action, $urandom_range(127), 2'($urandom_range(3)), $urandom, x, y, z);
  endtask

  function automatic coord_t rand_split();
    case ($urandom_range(7))
      0: rand_split = C_MAX;
      1: rand_split = C_MIN;
      2: rand_split = '0;
      3, 4: rand_split = coord_t'($urandom_range(32'h7FFFF)) - 32'sh40000;
      default: rand_split = coord_t'($urandom);
    endcase
  endfunction

  // Query coordinates land on, just above or just below recent splits, or are drawn like a split.
  function automatic coord_t pick_coord();
    int r;
    r = $urandom_range(9);
    if (r >= 5 && split_pool.size() > 0)
      pick_coord = split_pool[$urandom_range(split_pool.size() - 1)]
                   + coord_t'($urandom_range(2)) - 32'sd1;
    else
      pick_coord = rand_split();
  endfunction

  task automatic rand_query();
    put_query($urandom_range(1) ? ACT_POINT : ACT_DIRECTION,
              pick_coord(), pick_coord(), pick_coord());
  endtask

  task automatic grow_subtree(input int slot, input int depth_left);
    if (depth_left == 0 || $urandom_range(99) < 25) begin
      put_write(slot, KIND_LEAF, $urandom);
    end else begin
      put_write(slot, 2'($urandom_range(2)), rand_split());
      if (2 * slot < NODE_SLOTS) begin
        grow_subtree(2 * slot, depth_left - 1);
        grow_subtree(2 * slot + 1, depth_left - 1);
      end
    end
  endtask

  // Fill every slot with splits, then turn the bottom row into 64 leaves.
  task automatic build_full_tree();
    for (int s = ROOT_SLOT; s < NODE_SLOTS; s++)
      put_write(s, 2'($urandom_range(2)), rand_split());
    repeat (2) rand_query();
    for (int s = NODE_SLOTS / 2; s < NODE_SLOTS; s++) put_write(s, KIND_LEAF, $urandom);
    repeat (3) rand_query();
  endtask

  // Mostly whole trees followed by queries, with stray writes and clears.
  task automatic run_random(input int budget);
    int r;
    int depth;
    while (phase_items < budget) begin
      r = $urandom_range(99);
      if (r < 60) begin
        if ($urandom_range(2) == 0) put_clear();
        depth = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
        grow_subtree(ROOT_SLOT, depth);
        repeat ($urandom_range(1, 4)) rand_query();
      end else if (r < 78) begin
        rand_query();
      end else if (r < 92) begin
        put_write($urandom_range(127), 2'($urandom_range(3)), $urandom);
      end else begin
        put_clear();
      end
    end
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_ch.valid || expected_leaves.size() != 0)
      @(posedge clk);
  endtask

  // Request driver: predict on each transfer, then offer the next command.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) walk_tree(held_cmd);
      if (!req_ch.valid || req_ch.ready) begin
        if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          held_cmd = req_backlog.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.action    <= held_cmd.action;
          req_ch.node_slot <= held_cmd.node_slot;
          req_ch.node_kind <= held_cmd.node_kind;
          req_ch.node_word <= held_cmd.node_word;
          req_ch.ref_x     <= held_cmd.ref_x;
          req_ch.ref_y     <= held_cmd.ref_y;
          req_ch.ref_z     <= held_cmd.ref_z;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure and a field-by-field check.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (res_ch.valid && res_ch.ready) begin
        if (expected_leaves.size() == 0) begin
          report_mismatch("unexpected result, index", res_ch.particle_index, '0);
        end else begin
          head_leaf = expected_leaves.pop_front();
          if (res_ch.particle_index !== head_leaf.particle_index)
            report_mismatch("particle_index", res_ch.particle_index, head_leaf.particle_index);
          if (res_ch.last !== head_leaf.last)
            report_mismatch("last", 32'(res_ch.last), 32'(head_leaf.last));
          if (res_ch.empty_res !== head_leaf.empty_res)
            report_mismatch("empty_res", 32'(res_ch.empty_res), 32'(head_leaf.empty_res));
        end
        results_checked++;
      end
    end
  end

  // Watchdog: work is pending but neither channel has made a transfer.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (req_backlog.size() == 0 && !req_ch.valid && expected_leaves.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles < STALL_LIMIT) begin
      stall_cycles <= stall_cycles + 1;
    end else begin
      $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("bsp_tree_depth_order_traversal_core test failed");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.action = ACT_CLEAR;
    req_ch.node_slot = '0;
    req_ch.node_kind = KIND_X;
    req_ch.node_word = '0;
    req_ch.ref_x = '0;
    req_ch.ref_y = '0;
    req_ch.ref_z = '0;
    res_ch.ready = 1'b0;
    stall_cycles = 0;
    tree_loaded = 1'b0;
    gen_present = 1'b0;
    for (int s = 0; s < NODE_SLOTS; s++) gen_written[s] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // First phase: slow receiver, directed cases, a full tree, random trees.
    send_idle_pct = 8;
    recv_idle_pct = 78;
    phase_items = 0;
    // Queries on an empty tree, before and after a write to slot 0.
    put_query(ACT_POINT, '0, '0, '0);
    put_query(ACT_DIRECTION, C_MAX, C_MIN, '0);
    put_write(0, KIND_LEAF, 32'd5);
    put_query(ACT_POINT, 32'sd1, 32'sd1, 32'sd1);
    // A lone leaf at the root, with extreme indices.
    put_write(ROOT_SLOT, KIND_LEAF, C_MAX);
    put_query(ACT_DIRECTION, -32'sd1, -32'sd1, -32'sd1);
    put_write(ROOT_SLOT, KIND_LEAF, C_MIN);
    put_query(ACT_POINT, C_MIN, C_MIN, C_MIN);
    // A clear leaves the memory alone but empties the tree.
    put_clear();
    put_query(ACT_POINT, C_MAX, C_MAX, C_MAX);
    put_query(ACT_DIRECTION, C_MAX, C_MAX, C_MAX);
    // Two leaves under one split, on each axis; ties go to the odd child.
    put_write(2, KIND_LEAF, 32'd0);
    put_write(3, KIND_LEAF, 32'hFFFF_FFFF);
    put_write(ROOT_SLOT, KIND_X, C_MAX);
    put_query(ACT_POINT, C_MAX, '0, '0);
    put_write(ROOT_SLOT, KIND_Y, C_MIN);
    put_query(ACT_POINT, '0, C_MIN, '0);
    put_query(ACT_POINT, '0, C_MIN + 32'sd1, '0);
    put_write(ROOT_SLOT, KIND_Z, ONE_Q);
    put_query(ACT_POINT, '0, '0, ONE_Q + 32'sd1);
    put_query(ACT_DIRECTION, '0, '0, 32'sd1);
    put_query(ACT_DIRECTION, '0, '0, '0);
    put_query(ACT_DIRECTION, '0, '0, -32'sd1);
    build_full_tree();
    phase_items = 0;
    run_random(40);
    wait_drained();

    // Second phase: slow sender.
    send_idle_pct = 78;
    recv_idle_pct = 8;
    phase_items = 0;
    run_random(40);
    wait_drained();

    // Last phase: both sides at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_items = 0;
    run_random(40);
    wait_drained();

    // Let any late or extra result show up.
    repeat (2 * MAX_LEAVES + 8) @(posedge clk);
    $display("Ran %0d node writes, %0d clears, %0d point and %0d direction queries.",
             n_writes, n_clears, n_point, n_dir);
    $display("Checked %0d results: %0d empty, %0d full 64-leaf walks, %0d mismatches.",
             results_checked, n_empty, n_full_runs, mismatches);
    if (mismatches == 0 && expected_leaves.size() == 0) begin
      $display("bsp_tree_depth_order_traversal_core test passed");
    end else begin
      $display("bsp_tree_depth_order_traversal_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* bsp_tree_depth_order_traversal_core.f */
rtl/bspt_pkg.sv
rtl/bspt_if.sv
rtl/bspt_node_ram.sv
rtl/bspt_walker.sv
rtl/bspt_res_buf.sv
rtl/bsp_tree_depth_order_traversal_core.sv
rtl/bspt_checker.sv
dv/testbench.sv
